### hdl/stf_pkg.sv
//------------------------------------------------------------------------------
// stf_pkg: shared types and constants
// Fixed-point formats, register indexes and divider state for the midtone
// stretch pipeline.
//------------------------------------------------------------------------------
`default_nettype none
package stf_pkg;

    // Q16 unity and its width.
    localparam int unsigned UNITY_W = 17;
    localparam logic [UNITY_W-1:0] UNITY = 17'h10000;

    // Field widths.
    localparam int unsigned SAMPLE_W = 18;
    localparam int unsigned SHADOW_W = 16;
    localparam int unsigned INV_W = 20;
    localparam int unsigned MID_W = 16;
    localparam int unsigned PIX_W = 8;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 60;

    // Divider sizes: the quotient never exceeds 2^16, so 17 steps suffice.
    localparam int unsigned DEN_W = 33;
    localparam int unsigned Q_W = 17;
    localparam int unsigned DIV_STEPS = Q_W;

    // Pipeline depth: six front stages, the divider steps, one output stage.
    localparam int unsigned FRONT_STAGES = 6;
    localparam int unsigned STAGES = FRONT_STAGES + DIV_STEPS + 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHADOW_POINTS    = 8'd0,
        CFG_INVERSE_RANGES   = 8'd1,
        CFG_MIDTONE_BALANCES = 8'd2,
        CFG_INVERT_OUTPUT    = 8'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic [47:0] SHADOW_RESET = 48'd0;
    localparam logic [59:0] INV_RESET = 60'd4503603922341888;
    localparam logic [47:0] MID_RESET = 48'd140739635871744;

    // State carried through one divider step.
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   quo;
        logic             is_zero;
        logic             is_one;
    } div_state_t;

endpackage
`default_nettype wire

### hdl/stf_ifs.sv
//------------------------------------------------------------------------------
// stf interfaces: pixel and configuration channels
// Valid/ready channels for input pixels, output pixels and register writes.
//------------------------------------------------------------------------------
`default_nettype none
interface stf_pix_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [stf_pkg::SAMPLE_W-1:0]   red_in;
    logic signed [stf_pkg::SAMPLE_W-1:0]   green_in;
    logic signed [stf_pkg::SAMPLE_W-1:0]   blue_in;
    logic                                  last_in;

    modport source (output valid, red_in, green_in, blue_in, last_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, last_in, output ready);
endinterface

interface stf_pix_out_if;
    logic                         valid;
    logic                         ready;
    logic [stf_pkg::PIX_W-1:0]    red_out;
    logic [stf_pkg::PIX_W-1:0]    green_out;
    logic [stf_pkg::PIX_W-1:0]    blue_out;
    logic                         last_out;

    modport source (output valid, red_out, green_out, blue_out, last_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, last_out, output ready);
endinterface

interface stf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [stf_pkg::CFG_IDX_W-1:0]     index;
    logic [stf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/stf_midtone_stretch_rgb8.sv
//------------------------------------------------------------------------------
// stf_midtone_stretch_rgb8: RGB midtone stretch to 8-bit display values
// Accepts one pixel per cycle while the output beat is not held; each channel
// computes its quotient in a 17-stage divider pipeline.
// The whole pipeline holds while the output beat waits to be taken.
// Reset clears all valid bits and returns the registers to identity settings.
//------------------------------------------------------------------------------
`default_nettype none
module stf_midtone_stretch_rgb8 (
    input  wire logic      clk,
    input  wire logic      rst_n,
    stf_pix_in_if.sink     pix_in,
    stf_pix_out_if.source  pix_out,
    stf_cfg_if.sink        cfg
);

    localparam int unsigned NS = stf_pkg::STAGES;

    logic [47:0] shadow_reg;
    logic [59:0] inv_reg;
    logic [47:0] mid_reg;
    logic        invert_reg;
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] last_reg, last_next;
    logic        adv;

    // Pipeline advances when the output stage is empty or being taken.
    assign adv = !vld_reg[NS-1] || pix_out.ready;
    assign pix_in.ready = adv;
    assign cfg.ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= stf_pkg::SHADOW_RESET;
            inv_reg <= stf_pkg::INV_RESET;
            mid_reg <= stf_pkg::MID_RESET;
            invert_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                stf_pkg::CFG_SHADOW_POINTS:    shadow_reg <= cfg.data[47:0];
                stf_pkg::CFG_INVERSE_RANGES:   inv_reg <= cfg.data;
                stf_pkg::CFG_MIDTONE_BALANCES: mid_reg <= cfg.data[47:0];
                stf_pkg::CFG_INVERT_OUTPUT:    invert_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Valid bits and the last flag travel with the data.
    assign vld_next = {vld_reg[NS-2:0], pix_in.valid};
    assign last_next = {last_reg[NS-2:0], pix_in.last_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            last_reg <= last_next;
    end

    stf_channel u_red (
        .clk    (clk),
        .adv    (adv),
        .sample (pix_in.red_in),
        .shadow (shadow_reg[15:0]),
        .inv    (inv_reg[19:0]),
        .mid    (mid_reg[15:0]),
        .invert (invert_reg),
        .pixel  (pix_out.red_out)
    );

    stf_channel u_green (
        .clk    (clk),
        .adv    (adv),
        .sample (pix_in.green_in),
        .shadow (shadow_reg[31:16]),
        .inv    (inv_reg[39:20]),
        .mid    (mid_reg[31:16]),
        .invert (invert_reg),
        .pixel  (pix_out.green_out)
    );

    stf_channel u_blue (
        .clk    (clk),
        .adv    (adv),
        .sample (pix_in.blue_in),
        .shadow (shadow_reg[47:32]),
        .inv    (inv_reg[59:40]),
        .mid    (mid_reg[47:32]),
        .invert (invert_reg),
        .pixel  (pix_out.blue_out)
    );

    assign pix_out.valid = vld_reg[NS-1];
    assign pix_out.last_out = last_reg[NS-1];

`ifndef NO_ASSERTIONS
    // A stalled pipeline keeps every valid bit in place.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // An empty pipeline with no new beat cannot produce an output beat.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg == '0) && !pix_in.valid |=> !pix_out.valid)
        else $error("output beat appeared from an empty pipeline");

    // A beat that is taken at the output, with the stage before it empty, frees the final stage.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && pix_out.ready && !vld_reg[NS-2] |=> !pix_out.valid)
        else $error("output beat repeated");
`endif

endmodule
`default_nettype wire

### hdl/stf_front.sv
//------------------------------------------------------------------------------
// stf_front: clamp, shadow, range scale and curve terms
// Six register stages that turn one sample into the divider operands.
//------------------------------------------------------------------------------
`default_nettype none
module stf_front (
    input  wire logic                                 clk,
    input  wire logic                                 adv,
    input  wire logic signed [stf_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [stf_pkg::SHADOW_W-1:0]         shadow,
    input  wire logic [stf_pkg::INV_W-1:0]            inv,
    input  wire logic [stf_pkg::MID_W-1:0]            mid,
    output stf_pkg::div_state_t                       state
);

    localparam int unsigned PROD_W = stf_pkg::UNITY_W + stf_pkg::INV_W;

    logic [stf_pkg::UNITY_W-1:0] diff_reg, diff_next;
    logic [PROD_W-1:0]           prod_reg, prod_next;
    logic [stf_pkg::UNITY_W-1:0] x_reg, x_next;
    logic [stf_pkg::DEN_W-1:0]   num_reg, num_next;
    logic [stf_pkg::DEN_W-1:0]   mterm_reg, mterm_next;
    logic [stf_pkg::DEN_W-1:0]   num2_reg;
    logic [stf_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [1:0]                  flag4_reg, flag4_next;
    logic [1:0]                  flag5_reg;
    stf_pkg::div_state_t         out_reg, out_next;

    logic [stf_pkg::UNITY_W-1:0] clamped;
    logic [PROD_W-13:0]          prod_hi;
    logic [48:0]                 dividend;

    // Stage 1: clamp to [0,1] and subtract the shadow point.
    always_comb
    begin
        if (sample[stf_pkg::SAMPLE_W-1])
            clamped = '0;
        else if (sample > $signed({1'b0, stf_pkg::UNITY}))
            clamped = stf_pkg::UNITY;
        else
            clamped = sample[stf_pkg::UNITY_W-1:0];
        if (clamped > {1'b0, shadow})
            diff_next = clamped - {1'b0, shadow};
        else
            diff_next = '0;
    end

    // Stage 2: scale by the inverse range.
    assign prod_next = PROD_W'(diff_reg) * PROD_W'(inv);

    // Stage 3: drop to Q16 and saturate at one.
    assign prod_hi = prod_reg[PROD_W-1:12];
    assign x_next = (prod_hi > {{(PROD_W-12-stf_pkg::UNITY_W){1'b0}}, stf_pkg::UNITY})
                  ? stf_pkg::UNITY : prod_hi[stf_pkg::UNITY_W-1:0];

    // Stage 4: the two curve products (1-m)x and m(1-x).
    always_comb
    begin
        num_next = stf_pkg::DEN_W'(stf_pkg::UNITY - {1'b0, mid})
                 * stf_pkg::DEN_W'(x_reg[15:0]);
        mterm_next = stf_pkg::DEN_W'(mid) * stf_pkg::DEN_W'(stf_pkg::UNITY - x_reg);
        flag4_next = {x_reg[16], (x_reg == '0)};
    end

    // Stage 5: denominator.
    assign den_next = num_reg + mterm_reg;

    // Stage 6: rounded dividend, split for the 17-step divider.
    always_comb
    begin
        dividend = {num2_reg[32:0], 16'd0} + {17'd0, den_reg[32:1]};
        out_next.den = den_reg;
        out_next.rem = {1'b0, dividend[48:17]};
        out_next.low = dividend[16:0];
        out_next.quo = '0;
        out_next.is_zero = flag5_reg[0];
        out_next.is_one = flag5_reg[1];
    end

    // Stage registers advance together.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= diff_next;
            prod_reg <= prod_next;
            x_reg <= x_next;
            num_reg <= num_next;
            mterm_reg <= mterm_next;
            flag4_reg <= flag4_next;
            num2_reg <= num_reg;
            den_reg <= den_next;
            flag5_reg <= flag4_reg;
            out_reg <= out_next;
        end
    end

    assign state = out_reg;

endmodule
`default_nettype wire

### hdl/stf_div_step.sv
//------------------------------------------------------------------------------
// stf_div_step: one restoring division step
// Brings in one dividend bit, compares with the denominator, registers.
//------------------------------------------------------------------------------
`default_nettype none
module stf_div_step (
    input  wire logic           clk,
    input  wire logic           adv,
    input  stf_pkg::div_state_t in_state,
    output stf_pkg::div_state_t out_state
);

    stf_pkg::div_state_t state_reg, state_next;
    logic [stf_pkg::DEN_W:0] trial;
    logic [stf_pkg::DEN_W:0] diff;

    // Shift one bit into the remainder and subtract when it fits.
    always_comb
    begin
        trial = {in_state.rem, in_state.low[stf_pkg::Q_W-1]};
        diff = trial - {1'b0, in_state.den};
        state_next = in_state;
        state_next.low = {in_state.low[stf_pkg::Q_W-2:0], 1'b0};
        if (trial >= {1'b0, in_state.den})
        begin
            state_next.rem = diff[stf_pkg::DEN_W-1:0];
            state_next.quo = {in_state.quo[stf_pkg::Q_W-2:0], 1'b1};
        end
        else
        begin
            state_next.rem = trial[stf_pkg::DEN_W-1:0];
            state_next.quo = {in_state.quo[stf_pkg::Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            state_reg <= state_next;
    end

    assign out_state = state_reg;

endmodule
`default_nettype wire

### hdl/stf_channel.sv
//------------------------------------------------------------------------------
// stf_channel: full stretch path for one color channel
// Front stages, the divider chain and the 8-bit quantizing stage.
//------------------------------------------------------------------------------
`default_nettype none
module stf_channel (
    input  wire logic                                 clk,
    input  wire logic                                 adv,
    input  wire logic signed [stf_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [stf_pkg::SHADOW_W-1:0]         shadow,
    input  wire logic [stf_pkg::INV_W-1:0]            inv,
    input  wire logic [stf_pkg::MID_W-1:0]            mid,
    input  wire logic                                 invert,
    output logic [stf_pkg::PIX_W-1:0]                 pixel
);

    stf_pkg::div_state_t chain [stf_pkg::DIV_STEPS+1];

    logic [stf_pkg::UNITY_W-1:0] v;
    logic [stf_pkg::UNITY_W-1:0] vsel;
    logic [24:0]                 scaled;
    logic [stf_pkg::PIX_W-1:0]   pixel_reg, pixel_next;

    stf_front u_front (
        .clk    (clk),
        .adv    (adv),
        .sample (sample),
        .shadow (shadow),
        .inv    (inv),
        .mid    (mid),
        .state  (chain[0])
    );

    // One quotient bit per stage.
    for (genvar i = 0; i < stf_pkg::DIV_STEPS; i++)
    begin : g_div
        stf_div_step u_step (
            .clk       (clk),
            .adv       (adv),
            .in_state  (chain[i]),
            .out_state (chain[i+1])
        );
    end

    // Output stage: end points, optional inversion, round to 8 bits.
    always_comb
    begin
        if (chain[stf_pkg::DIV_STEPS].is_zero)
            v = '0;
        else if (chain[stf_pkg::DIV_STEPS].is_one)
            v = stf_pkg::UNITY;
        else
            v = chain[stf_pkg::DIV_STEPS].quo;
        vsel = invert ? (stf_pkg::UNITY - v) : v;
        scaled = {vsel, 8'd0} - {8'd0, vsel} + 25'd32768;
        pixel_next = scaled[23:16];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pixel_reg <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule
`default_nettype wire

### verif/stf_midtone_stretch_rgb8_tb.sv
//------------------------------------------------------------------------------
// stf_midtone_stretch_rgb8_tb: self-checking bench for the RGB midtone stretch
// Drives pixels and register writes over valid/ready channels with random
// idling on both sides. A scoreboard predicts each output beat from the
// current register settings and compares it with what the block returns.
//------------------------------------------------------------------------------
`default_nettype none
module stf_midtone_stretch_rgb8_tb;

    // Expected output pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } display_pix_t;

    // Predicts display values and holds the pixels still in flight.
    class stretch_scoreboard;
        logic [47:0] shadow_reg;
        logic [59:0] inv_reg;
        logic [47:0] mid_reg;
        logic        invert_reg;
        display_pix_t pending[$];
        int errors;

        function void reset_regs();
            shadow_reg = stf_pkg::SHADOW_RESET;
            inv_reg = stf_pkg::INV_RESET;
            mid_reg = stf_pkg::MID_RESET;
            invert_reg = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(stf_pkg::cfg_index_t idx, logic [59:0] value);
            case (idx)
                stf_pkg::CFG_SHADOW_POINTS:    shadow_reg = value[47:0];
                stf_pkg::CFG_INVERSE_RANGES:   inv_reg = value;
                stf_pkg::CFG_MIDTONE_BALANCES: mid_reg = value[47:0];
                stf_pkg::CFG_INVERT_OUTPUT:    invert_reg = value[0];
                default: ;
            endcase
        endfunction

        // One channel: clamp, shadow and range, midtone curve, optional inversion, quantize.
        function logic [7:0] stretch(logic signed [17:0] sample, int ch);
            logic [16:0] clamped;
            logic [15:0] shadow;
            logic [19:0] inv;
            logic [15:0] mid;
            logic [63:0] prod;
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] x;
            logic [63:0] v;
            shadow = shadow_reg[16*ch +: 16];
            inv = inv_reg[20*ch +: 20];
            mid = mid_reg[16*ch +: 16];
            if (sample < 0)
                clamped = 17'd0;
            else if (sample > 18'sd65536)
                clamped = 17'h10000;
            else
                clamped = sample[16:0];
            if (clamped <= {1'b0, shadow})
                x = 0;
            else
            begin
                prod = ((64'(clamped) - 64'(shadow)) * 64'(inv)) >> 12;
                x = (prod > 64'd65536) ? 64'd65536 : prod;
            end
            if (x == 0)
                v = 0;
            else if (x >= 64'd65536)
                v = 64'd65536;
            else
            begin
                num = (64'd65536 - 64'(mid)) * x;
                den = num + 64'(mid) * (64'd65536 - x);
                v = ((num << 16) + (den >> 1)) / den;
                if (v > 64'd65536)
                    v = 64'd65536;
            end
            if (invert_reg)
                v = 64'd65536 - v;
            return 8'((v * 255 + 32768) >> 16);
        endfunction

        function void note_pixel(logic signed [17:0] r, logic signed [17:0] g,
                                 logic signed [17:0] b, logic last);
            display_pix_t p;
            p.red = stretch(r, 0);
            p.green = stretch(g, 1);
            p.blue = stretch(b, 2);
            p.last = last;
            pending.push_back(p);
        endfunction

        function void check_pixel(display_pix_t got);
            display_pix_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected output beat: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display({"Mismatch: expected r=%0d g=%0d b=%0d l=%0d, ",
                              "got r=%0d g=%0d b=%0d l=%0d"},
                             want.red, want.green, want.blue, want.last,
                             got.red, got.green, got.blue, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   idle_pct;
    stretch_scoreboard sb;

    stf_pix_in_if  pix_in();
    stf_pix_out_if pix_out();
    stf_cfg_if     cfg();

    stf_midtone_stretch_rgb8 u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in.sink),
        .pix_out (pix_out.source),
        .cfg     (cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Cycle limit: pipeline latency plus generous stalls for 2009 beats.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Sample accepted beats on both pixel channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && pix_in.valid && pix_in.ready)
            sb.note_pixel(pix_in.red_in, pix_in.green_in, pix_in.blue_in, pix_in.last_in);
        if (rst_n && pix_out.valid && pix_out.ready)
            sb.check_pixel({pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                            pix_out.last_out});
    end

    // Output back-pressure, random at idle_pct.
    always @(negedge clk)
        pix_out.ready <= ($urandom_range(99) >= idle_pct);

    task automatic write_reg(stf_pkg::cfg_index_t idx, logic [59:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Send one pixel, with a random gap before it.
    task automatic send_pixel(logic signed [17:0] r, logic signed [17:0] g,
                              logic signed [17:0] b, logic last);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.red_in <= r;
        pix_in.green_in <= g;
        pix_in.blue_in <= b;
        pix_in.last_in <= last;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
    endtask

    // Mostly in-range samples, some out of range on either side.
    function automatic logic signed [17:0] rand_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7)
            return 18'($urandom_range(65536));
        return 18'($urandom);
    endfunction

    task automatic drain();
        @(negedge clk);
        pix_in.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic random_pixels(int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'($urandom));
    endtask

    function automatic logic [59:0] rand_fields(int width);
        logic [59:0] v;
        v = 60'({$urandom, $urandom});
        return (width == 16) ? {12'd0, v[47:0]} : v;
    endfunction

    initial
    begin
        sb = new();
        sb.reset_regs();
        cycle_count = 0;
        idle_pct = 36;
        rst_n = 1'b0;
        pix_in.valid = 1'b0;
        pix_in.red_in = '0;
        pix_in.green_in = '0;
        pix_in.blue_in = '0;
        pix_in.last_in = 1'b0;
        pix_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = stf_pkg::CFG_SHADOW_POINTS;
        cfg.data = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes under reset settings.
        send_pixel(-18'sd131072, 18'sd131071, 18'sd0, 1'b0);
        send_pixel(18'sd65536, 18'sd65535, 18'sd1, 1'b1);
        send_pixel(18'sd32768, -18'sd1, 18'sd65537, 1'b0);
        send_pixel(18'sd16384, 18'sd49152, 18'sd100, 1'b1);
        drain();

        // Zero inverse range, zero midtone, inversion.
        write_reg(stf_pkg::CFG_INVERSE_RANGES, 60'd0);
        write_reg(stf_pkg::CFG_MIDTONE_BALANCES, 60'd0);
        send_pixel(18'sd40000, 18'sd65536, 18'sd1, 1'b0);
        drain();
        write_reg(stf_pkg::CFG_INVERT_OUTPUT, 60'd1);
        send_pixel(18'sd40000, 18'sd65536, 18'sd0, 1'b1);
        drain();
        // Maximum shadow, range and midtone; out-of-range index ignored.
        write_reg(stf_pkg::CFG_SHADOW_POINTS, 60'hFFFF_FFFF_FFFF);
        write_reg(stf_pkg::CFG_INVERSE_RANGES, 60'hFFF_FFFF_FFFF_FFFF);
        write_reg(stf_pkg::CFG_MIDTONE_BALANCES, 60'hFFFF_FFFF_FFFF);
        write_reg(stf_pkg::cfg_index_t'(8'hFF), 60'd0);
        send_pixel(18'sd65536, 18'sd65535, 18'sd131071, 1'b0);
        drain();
        write_reg(stf_pkg::CFG_SHADOW_POINTS, 60'd0);
        send_pixel(18'sd1, 18'sd65535, 18'sd30000, 1'b1);
        send_pixel(18'sd65536, 18'sd2, 18'sd100, 1'b0);
        drain();

        // Random settings across phases, one with no idling.
        for (int ph = 0; ph < 10; ph++)
        begin
            idle_pct = (ph == 4) ? 0 : 36;
            write_reg(stf_pkg::CFG_SHADOW_POINTS, rand_fields(16) & 60'h3FFF_3FFF_3FFF);
            write_reg(stf_pkg::CFG_INVERSE_RANGES,
                      (ph == 0) ? stf_pkg::INV_RESET : rand_fields(20));
            write_reg(stf_pkg::CFG_MIDTONE_BALANCES, rand_fields(16));
            write_reg(stf_pkg::CFG_INVERT_OUTPUT, 60'($urandom_range(1)));
            random_pixels(200);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hdl/stf_pkg.sv
hdl/stf_ifs.sv
hdl/stf_front.sv
hdl/stf_div_step.sv
hdl/stf_channel.sv
hdl/stf_midtone_stretch_rgb8.sv
verif/stf_midtone_stretch_rgb8_tb.sv
